[sv/sgsbm_pkg.sv]
// Shared types, codes and the microcode program of the stereo gain/biquad mixer.
// No dependencies; imported by sgsbm_datapath and the top level.
`timescale 1ns / 1ps

package sgsbm_pkg;

  // Smoothing step, 655/65536 per frame, as a multiplier operand
  localparam logic signed [24:0] SMOOTH_STEP = 25'sd655;

  // Reset value of the output gain (unity in Q2.14)
  localparam logic [15:0] OUT_GAIN_RESET = 16'd16384;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FEED_0     = 3'd0;
  localparam logic [2:0] REG_FEED_1     = 3'd1;
  localparam logic [2:0] REG_FEED_2     = 3'd2;
  localparam logic [2:0] REG_BACK_1     = 3'd3;
  localparam logic [2:0] REG_BACK_2     = 3'd4;
  localparam logic [2:0] REG_LEFT_GAIN  = 3'd5;
  localparam logic [2:0] REG_RIGHT_GAIN = 3'd6;
  localparam logic [2:0] REG_OUT_GAIN   = 3'd7;

  // Multiplier operand pairs
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MS_SMOOTH = 3'd0;  // (target - gain) * step
  localparam mul_sel_t MS_GAIN   = 3'd1;  // sample * gain
  localparam mul_sel_t MS_A0     = 3'd2;  // a0 * x
  localparam mul_sel_t MS_A1     = 3'd3;  // a1 * x1
  localparam mul_sel_t MS_A2     = 3'd4;  // a2 * x2
  localparam mul_sel_t MS_B1     = 3'd5;  // b1 * y1
  localparam mul_sel_t MS_B2     = 3'd6;  // b2 * y2
  localparam mul_sel_t MS_OUT    = 3'd7;  // y * output gain

  // Accumulator operations on the product register
  typedef logic [1:0] acc_op_t;
  localparam acc_op_t ACC_HOLD  = 2'd0;
  localparam acc_op_t ACC_LOAD8 = 2'd1;  // acc = p << 8
  localparam acc_op_t ACC_ADD8  = 2'd2;  // acc += p << 8
  localparam acc_op_t ACC_SUB   = 2'd3;  // acc -= p

  // Write-back targets
  typedef logic [2:0] wb_t;
  localparam wb_t WB_NONE = 3'd0;
  localparam wb_t WB_GAIN = 3'd1;  // smoothed gain from product
  localparam wb_t WB_X    = 3'd2;  // filter input from product
  localparam wb_t WB_Y    = 3'd3;  // filter output from accumulator, shift history
  localparam wb_t WB_OUT  = 3'd4;  // mixed result from product

  typedef logic [3:0] step_t;
  localparam step_t STEP_FIRST = 4'd0;

  // One control word of the program
  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    wb_t      wb;
    logic     last;
  } ucw_t;

  // Control toward the datapath
  typedef struct packed {
    logic     en;
    logic     ch;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    wb_t      wb;
  } ctl_t;

  // Per-channel program; the multiplier result is registered, so each
  // product is used one step after it is issued.
  function automatic ucw_t ucode(input step_t step);
    ucw_t w;
    begin
      w.mul_sel = MS_SMOOTH;
      w.acc_op  = ACC_HOLD;
      w.wb      = WB_NONE;
      w.last    = 1'b0;
      case (step)
        4'd0:  w.mul_sel = MS_SMOOTH;
        4'd1:  w.wb = WB_GAIN;
        4'd2:  w.mul_sel = MS_GAIN;
        4'd3:  w.wb = WB_X;
        4'd4:  w.mul_sel = MS_A0;
        4'd5:  begin
          w.mul_sel = MS_A1;
          w.acc_op  = ACC_LOAD8;
        end
        4'd6:  begin
          w.mul_sel = MS_A2;
          w.acc_op  = ACC_ADD8;
        end
        4'd7:  begin
          w.mul_sel = MS_B1;
          w.acc_op  = ACC_ADD8;
        end
        4'd8:  begin
          w.mul_sel = MS_B2;
          w.acc_op  = ACC_SUB;
        end
        4'd9:  w.acc_op = ACC_SUB;
        4'd10: w.wb = WB_Y;
        4'd11: w.mul_sel = MS_OUT;
        4'd12: begin
          w.wb   = WB_OUT;
          w.last = 1'b1;
        end
        default: w.last = 1'b1;
      endcase
      return w;
    end
  endfunction

endpackage

[sv/sgsbm_datapath.sv]
// Datapath of the mixer: shared 25x25 multiplier, 56-bit accumulator,
// smoothed gains and per-channel biquad history. Depends on sgsbm_pkg.
`timescale 1ns / 1ps

module sgsbm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sgsbm_pkg::ctl_t     ctl,
  input  logic signed [23:0]  coef_feed_0,
  input  logic signed [23:0]  coef_feed_1,
  input  logic signed [23:0]  coef_feed_2,
  input  logic signed [23:0]  coef_back_1,
  input  logic signed [23:0]  coef_back_2,
  input  logic [15:0]         left_target_gain,
  input  logic [15:0]         right_target_gain,
  input  logic [15:0]         output_gain,
  input  logic signed [15:0]  left_smp,
  input  logic signed [15:0]  right_smp,
  input  logic signed [23:0]  left_mix,
  input  logic signed [23:0]  right_mix,
  input  logic                acc_on,
  output logic signed [23:0]  res_left,
  output logic signed [23:0]  res_now
);
  import sgsbm_pkg::*;

  logic [23:0]        gain_l;
  logic [23:0]        gain_r;
  logic signed [15:0] x1 [2];
  logic signed [15:0] x2 [2];
  logic signed [23:0] y1 [2];
  logic signed [23:0] y2 [2];
  logic signed [15:0] xcur;
  logic signed [49:0] p;
  logic signed [55:0] acc;

  logic [23:0]        gain_cur;
  logic [15:0]        tgt;
  logic signed [15:0] smp;
  logic signed [23:0] mix;
  logic signed [24:0] diff;
  logic signed [24:0] opa;
  logic signed [24:0] opb;
  logic signed [55:0] p_ext;

  logic signed [49:0] gr;
  logic signed [26:0] gsum;
  logic [23:0]        gain_next;
  logic signed [49:0] xr;
  logic signed [15:0] x_next;
  logic signed [55:0] yr;
  logic signed [23:0] y_next;
  logic signed [49:0] sr;
  logic signed [49:0] osum;

  // Pick the channel's operands
  always_comb begin
    gain_cur = ctl.ch ? gain_r : gain_l;
    tgt      = ctl.ch ? right_target_gain : left_target_gain;
    smp      = ctl.ch ? right_smp : left_smp;
    mix      = ctl.ch ? right_mix : left_mix;
    diff     = $signed({1'b0, tgt, 8'b0}) - $signed({1'b0, gain_cur});
  end

  // Operand mux of the shared multiplier
  always_comb begin
    case (ctl.mul_sel)
      MS_SMOOTH: begin
        opa = diff;
        opb = SMOOTH_STEP;
      end
      MS_GAIN: begin
        opa = {{9{smp[15]}}, smp};
        opb = $signed({1'b0, gain_cur});
      end
      MS_A0: begin
        opa = {coef_feed_0[23], coef_feed_0};
        opb = {{9{xcur[15]}}, xcur};
      end
      MS_A1: begin
        opa = {coef_feed_1[23], coef_feed_1};
        opb = {{9{x1[ctl.ch][15]}}, x1[ctl.ch]};
      end
      MS_A2: begin
        opa = {coef_feed_2[23], coef_feed_2};
        opb = {{9{x2[ctl.ch][15]}}, x2[ctl.ch]};
      end
      MS_B1: begin
        opa = {coef_back_1[23], coef_back_1};
        opb = {y1[ctl.ch][23], y1[ctl.ch]};
      end
      MS_B2: begin
        opa = {coef_back_2[23], coef_back_2};
        opb = {y2[ctl.ch][23], y2[ctl.ch]};
      end
      MS_OUT: begin
        opa = {y1[ctl.ch][23], y1[ctl.ch]};
        opb = $signed({9'b0, output_gain});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Register the product and run the accumulator
  assign p_ext = {{6{p[49]}}, p};

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p <= opa * opb;
      case (ctl.acc_op)
        ACC_LOAD8: acc <= p_ext <<< 8;
        ACC_ADD8:  acc <= acc + (p_ext <<< 8);
        ACC_SUB:   acc <= acc - p_ext;
        default:   acc <= acc;
      endcase
    end
  end

  // Write-back values: round half up, then clamp or saturate
  always_comb begin
    gr   = (p + 50'sd32768) >>> 16;
    gsum = $signed({3'b0, gain_cur}) + gr[26:0];
    if (gsum[26]) begin
      gain_next = '0;
    end else if (gsum[25:24] != 2'b00) begin
      gain_next = 24'hFFFFFF;
    end else begin
      gain_next = gsum[23:0];
    end

    xr = (p + 50'sd2097152) >>> 22;
    if (xr > 50'sd32767) begin
      x_next = 16'sh7FFF;
    end else if (xr < -50'sd32768) begin
      x_next = -16'sh8000;
    end else begin
      x_next = xr[15:0];
    end

    yr = (acc + 56'sd524288) >>> 20;
    if (yr > 56'sd8388607) begin
      y_next = 24'sh7FFFFF;
    end else if (yr < -56'sd8388608) begin
      y_next = -24'sh800000;
    end else begin
      y_next = yr[23:0];
    end

    sr   = (p + 50'sd8192) >>> 14;
    osum = sr + (acc_on ? {{26{mix[23]}}, mix} : 50'sd0);
    if (osum > 50'sd8388607) begin
      res_now = 24'sh7FFFFF;
    end else if (osum < -50'sd8388608) begin
      res_now = -24'sh800000;
    end else begin
      res_now = osum[23:0];
    end
  end

  // Gain and history state
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_l <= '0;
      gain_r <= '0;
      for (int i = 0; i < 2; i++) begin
        x1[i] <= '0;
        x2[i] <= '0;
        y1[i] <= '0;
        y2[i] <= '0;
      end
    end else if (ctl.en) begin
      case (ctl.wb)
        WB_GAIN: begin
          if (ctl.ch) begin
            gain_r <= gain_next;
          end else begin
            gain_l <= gain_next;
          end
        end
        WB_Y: begin
          x2[ctl.ch] <= x1[ctl.ch];
          x1[ctl.ch] <= xcur;
          y2[ctl.ch] <= y1[ctl.ch];
          y1[ctl.ch] <= y_next;
        end
        default: ;
      endcase
    end
  end

  // Current filter input and held left result
  always_ff @(posedge clk) begin
    if (ctl.en && ctl.wb == WB_X) begin
      xcur <= x_next;
    end
    if (ctl.en && ctl.wb == WB_OUT && !ctl.ch) begin
      res_left <= res_now;
    end
  end

endmodule

[sv/stereo_gain_smooth_biquad_mixer.sv]
// Top level of the stereo gain-smoothing biquad mixer: request handshake,
// APB register file and the microcode sequencer. Depends on sgsbm_pkg and
// sgsbm_datapath.
`timescale 1ns / 1ps

// A frame is taken when in_valid is high and in_stall low; in_stall stays
// high while the frame is worked. Each frame runs a 13-step program twice,
// once per channel, on one shared 25x25 multiplier, so a new frame is not
// taken until the previous frame's program has finished. The result
// sits in an output register while the next frame runs; only when a result
// is still unclaimed at the end of a frame does the sequencer wait on its
// last step. Register writes belong to idle periods between frames.

module stereo_gain_smooth_biquad_mixer (
  input  logic               clk,
  input  logic               rst,
  // input request
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic signed [23:0] left_mix_in,
  input  logic signed [23:0] right_mix_in,
  input  logic               accumulate,
  input  logic               frame_last,
  // output request
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] left_out,
  output logic signed [23:0] right_out,
  output logic               frame_last_out,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sgsbm_pkg::*;

  logic signed [23:0] coef_feed_0;
  logic signed [23:0] coef_feed_1;
  logic signed [23:0] coef_feed_2;
  logic signed [23:0] coef_back_1;
  logic signed [23:0] coef_back_2;
  logic [15:0]        left_target_gain;
  logic [15:0]        right_target_gain;
  logic [15:0]        output_gain;

  logic signed [15:0] left_smp;
  logic signed [15:0] right_smp;
  logic signed [23:0] left_mix;
  logic signed [23:0] right_mix;
  logic               acc_on;
  logic               last_flag;

  logic               running;
  logic               ch;
  step_t              step;
  ucw_t               uc;
  logic               hold;
  logic               adv;
  logic               finish;
  ctl_t               ctl;
  logic [2:0]         reg_idx;
  logic signed [23:0] res_left;
  logic signed [23:0] res_now;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_feed_0       <= '0;
      coef_feed_1       <= '0;
      coef_feed_2       <= '0;
      coef_back_1       <= '0;
      coef_back_2       <= '0;
      left_target_gain  <= '0;
      right_target_gain <= '0;
      output_gain       <= OUT_GAIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_FEED_0:     coef_feed_0       <= pwdata[23:0];
        REG_FEED_1:     coef_feed_1       <= pwdata[23:0];
        REG_FEED_2:     coef_feed_2       <= pwdata[23:0];
        REG_BACK_1:     coef_back_1       <= pwdata[23:0];
        REG_BACK_2:     coef_back_2       <= pwdata[23:0];
        REG_LEFT_GAIN:  left_target_gain  <= pwdata[15:0];
        REG_RIGHT_GAIN: right_target_gain <= pwdata[15:0];
        REG_OUT_GAIN:   output_gain       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_FEED_0:     prdata = {8'b0, coef_feed_0};
      REG_FEED_1:     prdata = {8'b0, coef_feed_1};
      REG_FEED_2:     prdata = {8'b0, coef_feed_2};
      REG_BACK_1:     prdata = {8'b0, coef_back_1};
      REG_BACK_2:     prdata = {8'b0, coef_back_2};
      REG_LEFT_GAIN:  prdata = {16'b0, left_target_gain};
      REG_RIGHT_GAIN: prdata = {16'b0, right_target_gain};
      REG_OUT_GAIN:   prdata = {16'b0, output_gain};
      default:        prdata = '0;
    endcase
  end

  // Sequencer control
  assign in_stall = running;
  assign uc       = ucode(step);
  assign hold     = running && uc.last && ch && out_valid && out_stall;
  assign adv      = running && !hold;
  assign finish   = adv && uc.last && ch;

  assign ctl.en      = adv;
  assign ctl.ch      = ch;
  assign ctl.mul_sel = uc.mul_sel;
  assign ctl.acc_op  = uc.acc_op;
  assign ctl.wb      = uc.wb;

  // Advance the step counter; jump back for the second channel
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      ch      <= 1'b0;
      step    <= STEP_FIRST;
    end else if (in_valid && !in_stall) begin
      running <= 1'b1;
      ch      <= 1'b0;
      step    <= STEP_FIRST;
    end else if (adv) begin
      if (uc.last) begin
        step <= STEP_FIRST;
        if (ch) begin
          running <= 1'b0;
        end else begin
          ch <= 1'b1;
        end
      end else begin
        step <= step + 4'd1;
      end
    end
  end

  // Capture the frame
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      left_smp  <= left_sample;
      right_smp <= right_sample;
      left_mix  <= left_mix_in;
      right_mix <= right_mix_in;
      acc_on    <= accumulate;
      last_flag <= frame_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      left_out       <= res_left;
      right_out      <= res_now;
      frame_last_out <= last_flag;
    end
  end

  sgsbm_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .coef_feed_0       (coef_feed_0),
    .coef_feed_1       (coef_feed_1),
    .coef_feed_2       (coef_feed_2),
    .coef_back_1       (coef_back_1),
    .coef_back_2       (coef_back_2),
    .left_target_gain  (left_target_gain),
    .right_target_gain (right_target_gain),
    .output_gain       (output_gain),
    .left_smp          (left_smp),
    .right_smp         (right_smp),
    .left_mix          (left_mix),
    .right_mix         (right_mix),
    .acc_on            (acc_on),
    .res_left          (res_left),
    .res_now           (res_now)
  );

endmodule
